>>> rtl/pzc_pkg.sv
// ----------------------------------------------------------------------------
// pzc_pkg
// Shared types and constants of the patch zncc cost block.
// ----------------------------------------------------------------------------
package pzc_pkg;

  localparam int unsigned MAX_PATCH_ELEMENTS = 64;
  localparam int unsigned CNT_W  = $clog2(MAX_PATCH_ELEMENTS + 1);
  localparam int unsigned SUM_W  = 16 + $clog2(MAX_PATCH_ELEMENTS);
  localparam int unsigned SQ_W   = 32 + $clog2(MAX_PATCH_ELEMENTS);
  localparam int unsigned PROD_W = CNT_W + SQ_W;

  localparam logic [16:0] COST_HALF = 17'd32768;

  typedef struct packed {
    logic [15:0] left_sample;
    logic [15:0] right_sample;
    logic        last_of_patch;
  } pzc_in_t;

  typedef struct packed {
    logic [16:0] match_cost;
    logic        flat_patch;
  } pzc_out_t;

  // sums of one finished patch
  typedef struct packed {
    logic [CNT_W-1:0] n;
    logic [SUM_W-1:0] sl;
    logic [SUM_W-1:0] sr;
    logic [SQ_W-1:0]  sll;
    logic [SQ_W-1:0]  srr;
    logic [SQ_W-1:0]  slr;
  } pzc_snap_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_A,
    ST_MUL_B,
    ST_MUL_C,
    ST_SUB_C,
    ST_NORM,
    ST_SQRT,
    ST_DEN,
    ST_DIV_INIT,
    ST_DIV,
    ST_OUT
  } pzc_state_e;

endpackage

>>> rtl/patch_zncc_cost_top.sv
// ----------------------------------------------------------------------------
// patch_zncc_cost_top
// Zero-mean normalized cross-correlation cost of two streamed patches.
// ----------------------------------------------------------------------------
// Sample pairs are taken one per cycle while full is low and summed by the
// front end; each beat with last_of_patch hands the sums to a two-entry
// queue and the back end turns them into one cost. For a patch with
// variance on both sides the back end pops the sums, runs three multiply
// steps, one subtract step and the normalize shifts, then 31 square-root
// steps in two bit-serial root units, the product step, the divide setup,
// 18 restoring divide steps and the output step. A flat patch skips from
// the subtract step to the output step. Push is throttled through full
// once the queue holds two waiting patches.
module patch_zncc_cost_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  pzc_pkg::pzc_in_t  in_item_i,
  output logic              empty,
  input  logic              pop,
  output pzc_pkg::pzc_out_t res_item_o
);

  logic               accept, snap_push, snap_valid, snap_pop, res_valid;
  pzc_pkg::pzc_snap_t snap_in, snap_out;

  assign accept = push && !full;
  assign empty  = !res_valid;

  pzc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .item_i      (in_item_i),
    .snap_push_o (snap_push),
    .snap_o      (snap_in)
  );

  pzc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (snap_push),
    .data_i  (snap_in),
    .full_o  (full),
    .pop_i   (snap_pop),
    .valid_o (snap_valid),
    .data_o  (snap_out)
  );

  pzc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .snap_valid_i (snap_valid),
    .snap_i       (snap_out),
    .snap_pop_o   (snap_pop),
    .res_valid_o  (res_valid),
    .res_o        (res_item_o),
    .res_pop_i    (pop && !empty)
  );

endmodule

>>> rtl/pzc_front.sv
// ----------------------------------------------------------------------------
// pzc_front
// Accumulates the running sums, one sample pair per beat.
// ----------------------------------------------------------------------------
module pzc_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  pzc_pkg::pzc_in_t   item_i,
  output logic               snap_push_o,
  output pzc_pkg::pzc_snap_t snap_o
);

  logic [pzc_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic [pzc_pkg::SUM_W-1:0] sl_q, sl_d, sr_q, sr_d;
  logic [pzc_pkg::SQ_W-1:0]  sll_q, sll_d, srr_q, srr_d, slr_q, slr_d;
  logic [31:0]               ll, rr, lr;
  logic                      room;

  // products of the incoming pair
  assign ll   = 32'(item_i.left_sample) * 32'(item_i.left_sample);
  assign rr   = 32'(item_i.right_sample) * 32'(item_i.right_sample);
  assign lr   = 32'(item_i.left_sample) * 32'(item_i.right_sample);
  assign room = cnt_q < pzc_pkg::CNT_W'(pzc_pkg::MAX_PATCH_ELEMENTS);

  // updated sums, pairs beyond the limit are dropped
  always_comb begin
    cnt_d = cnt_q;
    sl_d  = sl_q;
    sr_d  = sr_q;
    sll_d = sll_q;
    srr_d = srr_q;
    slr_d = slr_q;
    if (room) begin
      cnt_d = cnt_q + 1'b1;
      sl_d  = sl_q + pzc_pkg::SUM_W'(item_i.left_sample);
      sr_d  = sr_q + pzc_pkg::SUM_W'(item_i.right_sample);
      sll_d = sll_q + pzc_pkg::SQ_W'(ll);
      srr_d = srr_q + pzc_pkg::SQ_W'(rr);
      slr_d = slr_q + pzc_pkg::SQ_W'(lr);
    end
  end

  assign snap_push_o = accept_i && item_i.last_of_patch;
  assign snap_o = '{n: cnt_d, sl: sl_d, sr: sr_d, sll: sll_d, srr: srr_d, slr: slr_d};

  // sum registers, cleared at the end of a patch
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      sl_q  <= '0;
      sr_q  <= '0;
      sll_q <= '0;
      srr_q <= '0;
      slr_q <= '0;
    end else if (accept_i) begin
      if (item_i.last_of_patch) begin
        cnt_q <= '0;
        sl_q  <= '0;
        sr_q  <= '0;
        sll_q <= '0;
        srr_q <= '0;
        slr_q <= '0;
      end else begin
        cnt_q <= cnt_d;
        sl_q  <= sl_d;
        sr_q  <= sr_d;
        sll_q <= sll_d;
        srr_q <= srr_d;
        slr_q <= slr_d;
      end
    end
  end

endmodule

>>> rtl/pzc_queue.sv
// ----------------------------------------------------------------------------
// pzc_queue
// Two-entry queue of finished patch sums between front and back.
// ----------------------------------------------------------------------------
module pzc_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  pzc_pkg::pzc_snap_t data_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               valid_o,
  output pzc_pkg::pzc_snap_t data_o
);

  pzc_pkg::pzc_snap_t mem_q [2];
  logic               wr_q, rd_q;
  logic [1:0]         cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign data_o  = mem_q[rd_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= ~wr_q;
      end
      if (pop_i) begin
        rd_q <= ~rd_q;
      end
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

endmodule

>>> rtl/pzc_isqrt.sv
// ----------------------------------------------------------------------------
// pzc_isqrt
// Bit-serial integer square root, one result bit per step.
// ----------------------------------------------------------------------------
module pzc_isqrt (
  input  logic        clk_i,
  input  logic        load_i,
  input  logic        step_i,
  input  logic [4:0]  bit_idx_i,
  input  logic [63:0] val_i,
  output logic [30:0] root_o
);

  logic [63:0] v_q, root_q, bit_v, cand;

  assign bit_v  = 64'd1 << {bit_idx_i, 1'b0};
  assign cand   = root_q + bit_v;
  assign root_o = root_q[30:0];

  // remainder and root registers
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      v_q    <= val_i;
      root_q <= '0;
    end else if (step_i) begin
      if (v_q >= cand) begin
        v_q    <= v_q - cand;
        root_q <= (root_q >> 1) + bit_v;
      end else begin
        root_q <= root_q >> 1;
      end
    end
  end

endmodule

>>> rtl/pzc_back.sv
// ----------------------------------------------------------------------------
// pzc_back
// Sequencer that turns one patch's sums into the correlation cost.
// ----------------------------------------------------------------------------
module pzc_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               snap_valid_i,
  input  pzc_pkg::pzc_snap_t snap_i,
  output logic               snap_pop_o,
  output logic               res_valid_o,
  output pzc_pkg::pzc_out_t  res_o,
  input  logic               res_pop_i
);

  pzc_pkg::pzc_state_e state_q, state_d;
  pzc_pkg::pzc_snap_t  snap_q;

  logic [pzc_pkg::PROD_W-1:0] p1_q, p2_q, p1_d, p2_d;
  logic [63:0]                a_q, b_q, mag_q, num_q, rem_q, dv_q;
  logic [61:0]                den_q;
  logic [46:0]                d;
  logic [6:0]                 sa_q, sb_q, s;
  logic                       neg_q;
  logic [4:0]                 cnt_q;
  logic [17:0]                quo_q;
  logic [30:0]                na, nb;
  logic                       res_valid_q;
  pzc_pkg::pzc_out_t          res_q;
  logic                       sq_load, sq_step, out_load;
  logic [16:0]                qsat, cost;

  // shared multipliers, operand set chosen by step
  always_comb begin
    case (state_q)
      pzc_pkg::ST_MUL_A: begin
        p1_d = pzc_pkg::PROD_W'(snap_q.n) * pzc_pkg::PROD_W'(snap_q.sll);
        p2_d = pzc_pkg::PROD_W'(snap_q.sl) * pzc_pkg::PROD_W'(snap_q.sl);
      end
      pzc_pkg::ST_MUL_B: begin
        p1_d = pzc_pkg::PROD_W'(snap_q.n) * pzc_pkg::PROD_W'(snap_q.srr);
        p2_d = pzc_pkg::PROD_W'(snap_q.sr) * pzc_pkg::PROD_W'(snap_q.sr);
      end
      default: begin
        p1_d = pzc_pkg::PROD_W'(snap_q.n) * pzc_pkg::PROD_W'(snap_q.slr);
        p2_d = pzc_pkg::PROD_W'(snap_q.sl) * pzc_pkg::PROD_W'(snap_q.sr);
      end
    endcase
  end

  assign s    = 7'((8'(sa_q) + 8'(sb_q)) >> 1);
  assign d    = den_q[61:15];
  assign qsat = (quo_q > 18'(pzc_pkg::COST_HALF)) ? pzc_pkg::COST_HALF : quo_q[16:0];
  assign cost = neg_q ? pzc_pkg::COST_HALF + qsat : pzc_pkg::COST_HALF - qsat;

  pzc_isqrt u_sqrt_a (
    .clk_i     (clk_i),
    .load_i    (sq_load),
    .step_i    (sq_step),
    .bit_idx_i (cnt_q),
    .val_i     (a_q),
    .root_o    (na)
  );

  pzc_isqrt u_sqrt_b (
    .clk_i     (clk_i),
    .load_i    (sq_load),
    .step_i    (sq_step),
    .bit_idx_i (cnt_q),
    .val_i     (b_q),
    .root_o    (nb)
  );

  // next state and strobes
  always_comb begin
    state_d    = state_q;
    snap_pop_o = 1'b0;
    sq_load    = 1'b0;
    sq_step    = 1'b0;
    out_load   = 1'b0;
    case (state_q)
      pzc_pkg::ST_IDLE: begin
        if (snap_valid_i) begin
          snap_pop_o = 1'b1;
          state_d    = pzc_pkg::ST_MUL_A;
        end
      end
      pzc_pkg::ST_MUL_A: state_d = pzc_pkg::ST_MUL_B;
      pzc_pkg::ST_MUL_B: state_d = pzc_pkg::ST_MUL_C;
      pzc_pkg::ST_MUL_C: state_d = pzc_pkg::ST_SUB_C;
      pzc_pkg::ST_SUB_C: begin
        if (a_q == '0 || b_q == '0) begin
          state_d = pzc_pkg::ST_OUT;
        end else begin
          state_d = pzc_pkg::ST_NORM;
        end
      end
      pzc_pkg::ST_NORM: begin
        if (a_q[61:60] != 2'b00 && b_q[61:60] != 2'b00) begin
          sq_load = 1'b1;
          state_d = pzc_pkg::ST_SQRT;
        end
      end
      pzc_pkg::ST_SQRT: begin
        sq_step = 1'b1;
        if (cnt_q == '0) begin
          state_d = pzc_pkg::ST_DEN;
        end
      end
      pzc_pkg::ST_DEN:      state_d = pzc_pkg::ST_DIV_INIT;
      pzc_pkg::ST_DIV_INIT: state_d = pzc_pkg::ST_DIV;
      pzc_pkg::ST_DIV: begin
        if (cnt_q == '0) begin
          state_d = pzc_pkg::ST_OUT;
        end
      end
      pzc_pkg::ST_OUT: begin
        if (!res_valid_q || res_pop_i) begin
          out_load = 1'b1;
          state_d  = pzc_pkg::ST_IDLE;
        end
      end
      default: state_d = pzc_pkg::ST_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pzc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (snap_pop_o) begin
      snap_q <= snap_i;
    end
    p1_q <= p1_d;
    p2_q <= p2_d;
    case (state_q)
      pzc_pkg::ST_MUL_B: a_q <= 64'(p1_q - p2_q);
      pzc_pkg::ST_MUL_C: b_q <= 64'(p1_q - p2_q);
      pzc_pkg::ST_SUB_C: begin
        neg_q <= p1_q < p2_q;
        mag_q <= (p1_q < p2_q) ? 64'(p2_q - p1_q) : 64'(p1_q - p2_q);
        sa_q  <= '0;
        sb_q  <= '0;
      end
      pzc_pkg::ST_NORM: begin
        if (a_q[61:60] == 2'b00) begin
          a_q  <= a_q << 2;
          sa_q <= sa_q + 7'd2;
        end
        if (b_q[61:60] == 2'b00) begin
          b_q  <= b_q << 2;
          sb_q <= sb_q + 7'd2;
        end
        cnt_q <= 5'd30;
      end
      pzc_pkg::ST_SQRT: cnt_q <= cnt_q - 1'b1;
      pzc_pkg::ST_DEN: begin
        den_q <= 62'(na) * 62'(nb);
        num_q <= mag_q << s;
      end
      pzc_pkg::ST_DIV_INIT: begin
        rem_q <= num_q + 64'(d >> 1);
        dv_q  <= {d, 17'd0};
        quo_q <= '0;
        cnt_q <= 5'd17;
      end
      pzc_pkg::ST_DIV: begin
        if (rem_q >= dv_q) begin
          rem_q <= rem_q - dv_q;
          quo_q <= {quo_q[16:0], 1'b1};
        end else begin
          quo_q <= {quo_q[16:0], 1'b0};
        end
        dv_q  <= dv_q >> 1;
        cnt_q <= cnt_q - 1'b1;
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (out_load) begin
      res_valid_q <= 1'b1;
    end else if (res_pop_i) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      if (a_q == '0 || b_q == '0) begin
        res_q <= '{match_cost: pzc_pkg::COST_HALF, flat_patch: 1'b1};
      end else begin
        res_q <= '{match_cost: cost, flat_patch: 1'b0};
      end
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule
